// ----- rtl/core/bslx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream lexer package
// Token type codes, scan modes, the command that passes from the classifier
// to the emitter, and the constant keyword and symbol tables.
// ----------------------------------------------------------------------------
package bslx_pkg;

    typedef enum logic [3:0] {
        TT_NUMBER   = 4'd0,
        TT_KEYWORD  = 4'd1,
        TT_ASSIGN   = 4'd2,
        TT_LPAREN   = 4'd3,
        TT_RPAREN   = 4'd4,
        TT_IDENT    = 4'd5,
        TT_OPERATOR = 4'd6,
        TT_LBRACE   = 4'd7,
        TT_RBRACE   = 4'd8,
        TT_SEMI     = 4'd9,
        TT_QUOTE    = 4'd10,
        TT_END      = 4'd11
    } tok_type_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_WORD   = 3'b010,
        MODE_NUMBER = 3'b100
    } scan_mode_t;

    // Fixed part of a command; the run length travels beside it.
    typedef struct packed {
        tok_type_t run_type;
        logic      single_valid;
        tok_type_t single_type;
    } cmd_tail_t;

    localparam int KW_COUNT = 10;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;

    // Keyword text, last character in the lowest byte.
    function automatic logic [63:0] kw_text(input logic [3:0] k);
        logic [63:0] t;
        case (k)
            4'd0:    t = 64'("if");
            4'd1:    t = 64'("else");
            4'd2:    t = 64'("while");
            4'd3:    t = 64'("for");
            4'd4:    t = 64'("return");
            4'd5:    t = 64'("break");
            4'd6:    t = 64'("continue");
            4'd7:    t = 64'("switch");
            4'd8:    t = 64'("case");
            4'd9:    t = 64'("default");
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] l;
        case (k)
            4'd0:    l = 4'd2;
            4'd1:    l = 4'd4;
            4'd2:    l = 4'd5;
            4'd3:    l = 4'd3;
            4'd4:    l = 4'd6;
            4'd5:    l = 4'd5;
            4'd6:    l = 4'd8;
            4'd7:    l = 4'd6;
            4'd8:    l = 4'd4;
            4'd9:    l = 4'd7;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // Character p (counted from the start) of keyword k; p must be below its length.
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [63:0] t;
        logic [2:0]  i;
        t = kw_text(k);
        i = 3'(kw_len(k) - 4'd1 - {1'b0, p});
        return t[{i, 3'b000} +: 8];
    endfunction

    function automatic tok_type_t sym_type(input logic [7:0] c);
        tok_type_t t;
        case (c)
            8'h28:   t = TT_LPAREN;
            8'h29:   t = TT_RPAREN;
            8'h7B:   t = TT_LBRACE;
            8'h7D:   t = TT_RBRACE;
            8'h3B:   t = TT_SEMI;
            8'h3D:   t = TT_ASSIGN;
            8'h2B, 8'h2D, 8'h2A, 8'h2F: t = TT_OPERATOR;
            default: t = TT_IDENT;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bslx_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream lexer front end
// Accepts source bytes, tracks the pending token and its keyword match, and
// issues one emit command for every byte that causes results.
// ----------------------------------------------------------------------------
module bslx_front #(
    parameter int TOKEN_CHARS = 32,
    parameter int LW          = 6
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [7:0]             ch,
    input  wire                   end_of_file,
    input  wire                   q_full,
    output logic                  push,
    output logic [LW-1:0]         run_count,
    output bslx_pkg::cmd_tail_t   tail
);
    import bslx_pkg::*;

    scan_mode_t            mode_reg, mode_next;
    logic [LW-1:0]         len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic                  quote_reg, quote_next;
    logic [KW_COUNT-1:0]   kw_reg, kw_next;
    logic [KW_COUNT-1:0]   kw_step, kw_first, kw_full;

    logic accept, is_letter, is_num, is_space, is_nl, is_dq, extend, kw_hit;
    tok_type_t flush_type;
    logic [LW-1:0] flush_cnt;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    assign is_letter = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    assign is_num    = ch inside {[8'h30:8'h39]};
    assign is_space  = ch == CH_SPACE;
    assign is_nl     = ch == CH_NEWLINE;
    assign is_dq     = ch == CH_DQUOTE;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_step[k]  = kw_reg[k] && (len_reg < LW'(kw_len(4'(k))))
                          && (ch == kw_char(4'(k), len_reg[2:0]));
            kw_first[k] = ch == kw_char(4'(k), 3'd0);
            kw_full[k]  = kw_reg[k] && (len_reg == LW'(kw_len(4'(k))));
        end
    end

    assign kw_hit     = !ovf_reg && (|kw_full);
    assign flush_type = (mode_reg == MODE_WORD) ? (kw_hit ? TT_KEYWORD : TT_IDENT)
                                                : TT_NUMBER;
    assign flush_cnt  = (mode_reg == MODE_IDLE) ? '0 : len_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_WORD:   extend = is_letter || is_num || (is_space && quote_reg);
            MODE_NUMBER: extend = is_num;
            default:     extend = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        quote_next = quote_reg;
        kw_next    = kw_reg;
        push       = 1'b0;
        run_count  = flush_cnt;
        tail.run_type     = flush_type;
        tail.single_valid = 1'b0;
        tail.single_type  = TT_IDENT;
        if (accept)
        begin
            if (end_of_file)
            begin
                tail.single_valid = 1'b1;
                tail.single_type  = TT_END;
                push       = 1'b1;
                mode_next  = MODE_IDLE;
                len_next   = '0;
                ovf_next   = 1'b0;
                quote_next = 1'b0;
            end
            else if (extend)
            begin
                if (len_reg < LW'(TOKEN_CHARS))
                begin
                    len_next = len_reg + 1'b1;
                    kw_next  = kw_step;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                mode_next = MODE_IDLE;
                len_next  = '0;
                ovf_next  = 1'b0;
                if ((is_space && !quote_reg) || is_nl)
                begin
                    tail.single_valid = 1'b0;
                end
                else if (is_letter || is_num)
                begin
                    mode_next = is_letter ? MODE_WORD : MODE_NUMBER;
                    len_next  = LW'(1);
                    kw_next   = kw_first;
                end
                else if (is_dq)
                begin
                    quote_next        = !quote_reg;
                    tail.single_valid = 1'b1;
                    tail.single_type  = TT_QUOTE;
                end
                else
                begin
                    tail.single_valid = 1'b1;
                    tail.single_type  = sym_type(ch);
                end
                push = tail.single_valid || (flush_cnt != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            quote_reg <= 1'b0;
            kw_reg    <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            quote_reg <= quote_next;
            kw_reg    <= kw_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bslx_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream lexer command queue
// Small register FIFO holding emit commands between front and back end.
// ----------------------------------------------------------------------------
module bslx_cmd_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wire [WIDTH-1:0]   wdata,
    input  wire               pop,
    output logic [WIDTH-1:0]  rdata,
    output logic              full,
    output logic              empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem_reg[rd_reg];

    // Pointers wrap at the last entry, so any depth works.
    assign wr_next  = !push ? wr_reg :
                      (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign rd_next  = !pop ? rd_reg :
                      (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign cnt_next = cnt_reg + CW'(push) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bslx_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream lexer back end
// Replays each command as a run of typed words followed by an optional
// single word, one word per cycle while the output is taken, into a registered output.
// ----------------------------------------------------------------------------
module bslx_back #(
    parameter int LW = 6
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_empty,
    input  wire [LW-1:0]          q_count,
    input  bslx_pkg::cmd_tail_t   q_tail,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output bslx_pkg::tok_type_t   token_type
);
    import bslx_pkg::*;

    logic          vld_reg, vld_next;
    tok_type_t     out_reg, out_next;
    logic [LW-1:0] left_reg, left_next;
    tok_type_t     rtype_reg, rtype_next;
    logic          spend_reg, spend_next;
    tok_type_t     stype_reg, stype_next;
    logic          load;

    assign load       = !vld_reg || m_tready;
    assign m_tvalid   = vld_reg;
    assign token_type = out_reg;

    always_comb
    begin
        vld_next   = vld_reg;
        out_next   = out_reg;
        left_next  = left_reg;
        rtype_next = rtype_reg;
        spend_next = spend_reg;
        stype_next = stype_reg;
        pop        = 1'b0;
        if (load)
        begin
            vld_next = 1'b0;
            if (left_reg != '0)
            begin
                vld_next  = 1'b1;
                out_next  = rtype_reg;
                left_next = left_reg - 1'b1;
            end
            else if (spend_reg)
            begin
                vld_next   = 1'b1;
                out_next   = stype_reg;
                spend_next = 1'b0;
            end
            else if (!q_empty)
            begin
                pop        = 1'b1;
                vld_next   = 1'b1;
                rtype_next = q_tail.run_type;
                stype_next = q_tail.single_type;
                if (q_count != '0)
                begin
                    out_next   = q_tail.run_type;
                    left_next  = q_count - 1'b1;
                    spend_next = q_tail.single_valid;
                end
                else
                begin
                    out_next   = q_tail.single_type;
                    spend_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            left_reg  <= '0;
            spend_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            left_reg  <= left_next;
            spend_reg <= spend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        rtype_reg <= rtype_next;
        stype_reg <= stype_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/byte_stream_lexer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream lexer
// Splits a byte stream into tokens and sends one typed word per stored
// token character, plus one word per symbol, quote or end of file.
// ----------------------------------------------------------------------------
// Usage: source bytes enter on the s_ channel, one byte per word, with
// s_tuser set for the end-of-file word. Token types leave on the m_ channel.
// The front end takes one input word per cycle as long as the command queue
// has room; a byte that only extends a token or is skipped causes no output.
// A byte that ends a token, or a symbol, quote or end of file, queues one
// command. The back end replays a command as one word per cycle while the
// receiver takes them: one word for each stored character of the finished
// token, then the symbol word if any. Its first word is loaded from the
// queue into the output register, which raises m_tvalid. Both ends move
// one word per cycle when not stalled, so a stream in which most bytes are
// emitted once flows at close to the input rate; the queue lets the front
// end classify the next token while the back end replays this one. When
// the receiver stalls, the output register holds its word, the queue
// fills and s_tready drops; nothing is lost. Reset clears the scan mode,
// the quote flag, the queue and the output valid; the block is ready at once.
// ----------------------------------------------------------------------------
module byte_stream_lexer_unit #(
    parameter int TOKEN_CHARS = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [7:0] ch
    input  wire [0:0]  s_tuser,   // [0] end_of_file
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [3:0] token_type, [7:4] zero
);
    import bslx_pkg::*;

    // Run counts reach TOKEN_CHARS.
    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam int CMD_W = LW + $bits(cmd_tail_t);

    logic          push, pop, q_full, q_empty;
    logic [LW-1:0] run_count, q_count;
    cmd_tail_t     tail, q_tail;
    logic [CMD_W-1:0] q_rdata;
    tok_type_t     token_type;

    bslx_front #(
        .TOKEN_CHARS (TOKEN_CHARS),
        .LW          (LW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .ch          (s_tdata),
        .end_of_file (s_tuser[0]),
        .q_full      (q_full),
        .push        (push),
        .run_count   (run_count),
        .tail        (tail)
    );

    bslx_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({run_count, tail}),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_count = q_rdata[CMD_W-1 -: LW];
    assign q_tail  = cmd_tail_t'(q_rdata[$bits(cmd_tail_t)-1:0]);

    bslx_back #(
        .LW (LW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_count    (q_count),
        .q_tail     (q_tail),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .token_type (token_type)
    );

    assign m_tdata = {4'b0000, token_type};

`ifndef ASSERT_OFF
    // An accepted end of file always queues a command.
    a_eof_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |-> push)
        else $error("end of file did not queue a command");

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("command queue written while full");

    // The back end only pops a queue that holds a command.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("command queue read while empty");

    // Emitted types stay within the defined codes.
    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= TT_END))
        else $error("token type out of range");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream lexer testbench
// Feeds the lexer a short hand-written program fragment and then random
// token sequences: keywords, names, numbers, symbols, quotes, odd bytes and
// end-of-file words. A scoreboard tracks the scan state, predicts the token
// type of every output word and checks each one in order as it leaves.
// ----------------------------------------------------------------------------
module testbench;

    import bslx_pkg::*;

    localparam int TOKEN_CHARS   = 32;
    localparam int RANDOM_ITEMS  = 290;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AFTER    = 120;

    // Keeps the lexer's scan state and the queue of token types it must send.
    class lexer_scoreboard;
        tok_type_t   expected_tokens[$];
        logic [7:0]  chars[TOKEN_CHARS];
        int          char_count;
        scan_mode_t  mode;
        bit          quoted;
        bit          dropped;
        int          errors;
        int          words_checked;
        int          bytes_taken;
        int          eof_taken;
        int          keyword_tokens;
        int          clipped_tokens;

        function new();
            char_count = 0;
            mode       = MODE_IDLE;
            quoted     = 1'b0;
            dropped    = 1'b0;
        endfunction

        function string keyword_text(int k);
            case (k)
                0:       return "if";
                1:       return "else";
                2:       return "while";
                3:       return "for";
                4:       return "return";
                5:       return "break";
                6:       return "continue";
                7:       return "switch";
                8:       return "case";
                default: return "default";
            endcase
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // A clipped word can never match, since it no longer holds its text.
        function bit matches_keyword();
            string kw;
            bit    same;
            if (dropped)
                return 1'b0;
            for (int k = 0; k < 10; k++) begin
                kw = keyword_text(k);
                if (kw.len() == char_count) begin
                    same = 1'b1;
                    for (int i = 0; i < char_count; i++)
                        if (kw[i] != chars[i])
                            same = 1'b0;
                    if (same)
                        return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function tok_type_t symbol_kind(logic [7:0] c);
            case (c)
                "(":                return TT_LPAREN;
                ")":                return TT_RPAREN;
                "{":                return TT_LBRACE;
                "}":                return TT_RBRACE;
                ";":                return TT_SEMI;
                "=":                return TT_ASSIGN;
                "+", "-", "*", "/": return TT_OPERATOR;
                default:            return TT_IDENT;
            endcase
        endfunction

        function void add_char(logic [7:0] c);
            if (char_count < TOKEN_CHARS) begin
                chars[char_count] = c;
                char_count++;
            end else begin
                dropped = 1'b1;
            end
        endfunction

        function void open_token(scan_mode_t m, logic [7:0] c);
            mode       = m;
            char_count = 0;
            dropped    = 1'b0;
            add_char(c);
        endfunction

        // One word per stored character of the pending token.
        function void emit_pending();
            tok_type_t t;
            t = TT_NUMBER;
            if (mode == MODE_WORD) begin
                t = matches_keyword() ? TT_KEYWORD : TT_IDENT;
                if (t == TT_KEYWORD)
                    keyword_tokens++;
            end
            if (mode != MODE_IDLE) begin
                if (dropped)
                    clipped_tokens++;
                repeat (char_count)
                    expected_tokens.push_back(t);
            end
            mode       = MODE_IDLE;
            char_count = 0;
            dropped    = 1'b0;
        endfunction

        function void take_byte(logic [7:0] c, logic eof);
            if (eof) begin
                eof_taken++;
                emit_pending();
                expected_tokens.push_back(TT_END);
                quoted = 1'b0;
                return;
            end
            bytes_taken++;
            if (mode == MODE_WORD &&
                (is_letter(c) || is_num(c) || (c == CH_SPACE && quoted))) begin
                add_char(c);
                return;
            end
            if (mode == MODE_NUMBER && is_num(c)) begin
                add_char(c);
                return;
            end
            // Whatever ended the token is then handled as a fresh byte.
            emit_pending();
            if ((c == CH_SPACE && !quoted) || c == CH_NEWLINE)
                return;
            if (is_letter(c))
                open_token(MODE_WORD, c);
            else if (is_num(c))
                open_token(MODE_NUMBER, c);
            else if (c == CH_DQUOTE) begin
                quoted = !quoted;
                expected_tokens.push_back(TT_QUOTE);
            end else
                expected_tokens.push_back(symbol_kind(c));
        endfunction

        function void check_token(logic [7:0] word);
            tok_type_t want;
            words_checked++;
            if (expected_tokens.size() == 0) begin
                $error("token_type: expected none, got %0d", word[3:0]);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (word[3:0] != want) begin
                $error("token_type: expected %0d, got %0d", want, word[3:0]);
                errors++;
            end
            if (word[7:4] != 4'd0) begin
                $error("padding: expected 0, got %0d", word[7:4]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    lexer_scoreboard sb;
    bit              steady;      // when set, neither side idles
    int              items_sent;

    byte_stream_lexer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Offers one word and returns at the edge where it is taken. Valid stays
    // high on return, so back-to-back words need no gap.
    task automatic send_item(input logic [7:0] c, input logic eof);
        if (!steady)
        begin
            while ($urandom_range(99) < 11)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_byte(c, eof);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_eof();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] any_letter();
        return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    // Mostly well-formed program text with random content; now and then a
    // token longer than the buffer, a stray byte or an early end of file.
    task automatic send_random_text(input int count);
        int    stop_at;
        int    pick;
        int    len;
        string syms;
        syms    = "(){};=+-*/";
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            // A stretch in the middle runs with both sides always ready.
            steady = (items_sent >= stop_at - count + 100) && (items_sent < stop_at - count + 180);
            pick = $urandom_range(99);
            if (pick < 18)
            begin
                send_text(sb.keyword_text($urandom_range(9)));
                if ($urandom_range(9) < 7)
                    send_item(CH_SPACE, 1'b0);
            end
            else if (pick < 36)
            begin
                len = ($urandom_range(15) == 0) ? $urandom_range(40, 33) : $urandom_range(7, 1);
                send_item(any_letter(), 1'b0);
                for (int i = 1; i < len; i++)
                    send_item($urandom_range(3) == 0 ? any_digit() : any_letter(), 1'b0);
                if ($urandom_range(9) < 7)
                    send_item(CH_SPACE, 1'b0);
            end
            else if (pick < 48)
            begin
                len = ($urandom_range(15) == 0) ? $urandom_range(36, 32) : $urandom_range(5, 1);
                for (int i = 0; i < len; i++)
                    send_item(any_digit(), 1'b0);
            end
            else if (pick < 70)
                send_item(syms[$urandom_range(syms.len() - 1)], 1'b0);
            else if (pick < 80)
                send_item(CH_SPACE, 1'b0);
            else if (pick < 84)
                send_item(CH_NEWLINE, 1'b0);
            else if (pick < 89)
                send_item(CH_DQUOTE, 1'b0);
            else if (pick < 97)
                send_item(8'($urandom_range(255)), 1'b0);
            else
                send_eof();
        end
        steady = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off once traffic is
    // flowing so the queue fills and the input side has to back off.
    initial
    begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sb.words_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 11);
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_token(m_tdata);
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        sb         = new();
        steady     = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed fragment: a keyword, a number, every symbol, a quoted word
        // with a space, a lone space inside quotes, the byte extremes, a
        // newline, and an end of file that closes the open quote.
        send_text("if(9)=x;{+-*/}\"a b\" \" ");
        send_item(8'hFF, 1'b0);
        send_item(CH_NEWLINE, 1'b0);
        send_item(8'h00, 1'b0);
        send_eof();

        send_random_text(RANDOM_ITEMS);
        send_eof();
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d source bytes and %0d end-of-file words, %0d token words",
                 sb.bytes_taken, sb.eof_taken, sb.words_checked);
        $display("among them %0d keyword tokens and %0d tokens clipped at the buffer size",
                 sb.keyword_tokens, sb.clipped_tokens);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- byte_stream_lexer_unit.f -----
rtl/core/bslx_pkg.sv
rtl/core/bslx_front.sv
rtl/core/bslx_cmd_fifo.sv
rtl/core/bslx_back.sv
rtl/core/byte_stream_lexer_unit.sv
tb/testbench.sv
